>>> rtl/core/pims_pkg.sv
`timescale 1ns / 1ps

package pims_pkg;

    localparam int ONE_Q16 = 65536;
    localparam int FRAC_W = 16;
    localparam int DIV_W = 35;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_IOU          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_CHECK_IOU  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_RATIO_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VEHICLE_WEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OTHER_WEIGHT     = 3'd5;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SCORE = 1'b1;

    typedef struct packed {
        logic [15:0] min_iou;
        logic [15:0] shape_check_iou;
        logic [15:0] area_ratio_limit;
        logic [15:0] depth_scale;
        logic [15:0] vehicle_weight;
        logic [15:0] other_weight;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        min_iou:          16'd6554,
        shape_check_iou:  16'd19661,
        area_ratio_limit: 16'd512,
        depth_scale:      16'd2000,
        vehicle_weight:   16'd9830,
        other_weight:     16'd3277
    };

    // Geometry of one measurement against the tracker, ready for the divider.
    typedef struct packed {
        logic [32:0]        inter;
        logic signed [35:0] uni;
        logic [17:0]        depth_gap;
        logic               vehicle;
        logic               ratio_hit;
    } pair_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] quo;
    } div_rsp_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_IOU,
        B_GATE,
        B_SCORE,
        B_PROX,
        B_MUL,
        B_OUT
    } back_state_t;

endpackage

>>> rtl/core/pims_if.sv
`timescale 1ns / 1ps

interface pims_item_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] center;
    logic [15:0]        half_width;
    logic signed [15:0] z_low;
    logic signed [15:0] z_high;
    logic [17:0]        nearest_depth;
    logic [19:0]        footprint_area;
    logic               flag;

    modport source (
        output valid, kind, center, half_width, z_low, z_high,
               nearest_depth, footprint_area, flag,
        input  ready
    );

    modport sink (
        input  valid, kind, center, half_width, z_low, z_high,
               nearest_depth, footprint_area, flag,
        output ready
    );
endinterface

interface pims_result_if;
    logic        valid;
    logic        ready;
    logic [16:0] score;
    logic        passed_gate;
    logic        shape_change;

    modport source (
        output valid, score, passed_gate, shape_change,
        input  ready
    );

    modport sink (
        input  valid, score, passed_gate, shape_change,
        output ready
    );
endinterface

>>> rtl/core/perspective_iou_match_score_unit.sv
`timescale 1ns / 1ps

// Channel   Role    Word
// item      sink    kind, center, half_width, z_low, z_high, nearest_depth,
//                   footprint_area, flag
// result    source  score, passed_gate, shape_change
// wr_*      write   wr_en, wr_index, wr_data (no handshake)
//
// A load word gives no result. A score word passes through the front stages and then the back
// part, which runs the shared one-bit-a-cycle divider up to three times (IoU, rescaled IoU,
// depth proximity), then multiplies and rounds.
// The queue between front and back lets the front keep taking words while the back works.
// Reset clears the tracker footprint to zero and loads the register defaults.
// A stalled result holds in the output register; the back part waits there for it to leave.

module perspective_iou_match_score_unit #(
    parameter int QUEUE_DEPTH = pims_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    pims_item_if.sink                         item,
    pims_result_if.source                     result,
    input  logic                              wr_en,
    input  logic [pims_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [pims_pkg::CFG_DATA_W-1:0]   wr_data
);
    import pims_pkg::*;

    cfg_t     cfg_reg;
    pair_t    push_entry;
    pair_t    q_head;
    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MIN_IOU:          cfg_reg.min_iou          <= wr_data;
                REG_SHAPE_CHECK_IOU:  cfg_reg.shape_check_iou  <= wr_data;
                REG_AREA_RATIO_LIMIT: cfg_reg.area_ratio_limit <= wr_data;
                REG_DEPTH_SCALE:      cfg_reg.depth_scale      <= wr_data;
                REG_VEHICLE_WEIGHT:   cfg_reg.vehicle_weight   <= wr_data;
                REG_OTHER_WEIGHT:     cfg_reg.other_weight     <= wr_data;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    pims_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .area_ratio_limit (cfg_reg.area_ratio_limit),
        .item             (item),
        .push             (push),
        .entry            (push_entry),
        .full             (q_full)
    );

    pims_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (push_entry),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head),
        .pop      (q_pop)
    );

    pims_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pims_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .result  (result)
    );

endmodule

>>> rtl/core/pims_div.sv
`timescale 1ns / 1ps

module pims_div (
    input  logic               clk,
    input  logic               rst_n,
    input  pims_pkg::div_req_t req,
    output pims_pkg::div_rsp_t rsp
);
    import pims_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [FRAC_W-1:0] quo_reg;
    logic              sat_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    logic           fits;

    // One quotient bit per cycle; a numerator not below the divisor saturates to one.
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= CNT_W'(FRAC_W);
        end
        else if (run_reg && (cnt_reg != '0))
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
        else if (run_reg)
        begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            den_reg <= req.den;
            quo_reg <= '0;
            sat_reg <= req.num >= req.den;
        end
        else if (run_reg && (cnt_reg != '0))
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_reg <= {quo_reg[FRAC_W-2:0], fits};
        end
    end

    assign rsp.done = run_reg && (cnt_reg == '0);
    assign rsp.quo  = sat_reg ? 17'(ONE_Q16) : {1'b0, quo_reg};

endmodule

>>> rtl/core/pims_fifo.sv
`timescale 1ns / 1ps

module pims_fifo #(
    parameter int DEPTH = pims_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pims_pkg::pair_t wr_entry,
    output logic            full,
    output logic            valid,
    output pims_pkg::pair_t head,
    input  logic            pop
);
    import pims_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    pair_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_next;

    assign full  = count_reg == CW'(DEPTH);
    assign valid = count_reg != '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

>>> rtl/core/pims_front.sv
`timescale 1ns / 1ps

module pims_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     area_ratio_limit,
    pims_item_if.sink       item,
    output logic            push,
    output pims_pkg::pair_t entry,
    input  logic            full
);
    import pims_pkg::*;

    // Stored tracker footprint.
    logic signed [15:0] trk_center_reg;
    logic [15:0]        trk_half_width_reg;
    logic signed [15:0] trk_z_low_reg;
    logic signed [15:0] trk_z_high_reg;
    logic [17:0]        trk_depth_reg;
    logic [19:0]        trk_area_reg;
    logic               trk_vehicle_reg;

    logic               s1_valid_reg;
    logic [16:0]        s1_az_reg;
    logic [15:0]        s1_h_reg;
    logic [15:0]        s1_ha_reg;
    logic [15:0]        s1_hb_reg;
    logic signed [16:0] s1_hm_reg;
    logic signed [16:0] s1_ht_reg;
    logic [17:0]        s1_dd_reg;
    logic [19:0]        s1_big_reg;
    logic [19:0]        s1_small_reg;
    logic               s1_pre_reg;
    logic               s1_veh_reg;

    logic               s2_valid_reg;
    logic [32:0]        s2_inter_reg;
    logic signed [33:0] s2_am_reg;
    logic signed [33:0] s2_at_reg;
    logic [17:0]        s2_dd_reg;
    logic               s2_veh_reg;
    logic               s2_hit_reg;

    logic               accept;
    logic               s1_free;
    logic               s2_free;
    logic               s1_valid_next;
    logic               s2_valid_next;

    logic signed [15:0] dwrap;
    logic [16:0]        dabs;
    logic signed [18:0] ha_s;
    logic signed [18:0] hb_s;
    logic signed [18:0] d_s;
    logic signed [18:0] hi_a;
    logic signed [18:0] lo_a;
    logic signed [18:0] neg_ha;
    logic signed [18:0] az_top;
    logic signed [18:0] az_bot;
    logic signed [18:0] az_span;
    logic [16:0]        az_overlap;
    logic signed [15:0] zt;
    logic signed [15:0] zb;
    logic signed [16:0] hspan;
    logic [15:0]        h_inter;
    logic signed [16:0] hm;
    logic signed [16:0] ht;
    logic [17:0]        dd;
    logic [19:0]        big;
    logic [19:0]        small_area;
    logic               pre;

    logic [32:0]        inter;
    logic signed [32:0] am_p;
    logic signed [32:0] at_p;
    logic [35:0]        ratio_rhs;
    logic               ratio_hit;

    assign s2_free    = !s2_valid_reg || !full;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign item.ready = s1_free;
    assign accept     = item.valid && s1_free;
    assign push       = s2_valid_reg && !full;

    // Overlap in azimuth with the center difference wrapped to half a turn.
    always_comb
    begin
        dwrap   = item.center - trk_center_reg;
        dabs    = dwrap[15] ? (17'd0 - {dwrap[15], dwrap}) : {1'b0, dwrap};
        ha_s    = {3'b000, item.half_width};
        hb_s    = {3'b000, trk_half_width_reg};
        d_s     = {2'b00, dabs};
        hi_a    = d_s + hb_s;
        lo_a    = d_s - hb_s;
        neg_ha  = 19'sd0 - ha_s;
        az_top  = (ha_s < hi_a) ? ha_s : hi_a;
        az_bot  = (neg_ha > lo_a) ? neg_ha : lo_a;
        az_span = az_top - az_bot;
        az_overlap = az_span[18] ? '0 : az_span[16:0];

        zt      = (item.z_high < trk_z_high_reg) ? item.z_high : trk_z_high_reg;
        zb      = (item.z_low > trk_z_low_reg) ? item.z_low : trk_z_low_reg;
        hspan   = 17'(zt) - 17'(zb);
        h_inter = hspan[16] ? '0 : hspan[15:0];
        hm      = 17'(item.z_high) - 17'(item.z_low);
        ht      = 17'(trk_z_high_reg) - 17'(trk_z_low_reg);

        dd = (item.nearest_depth >= trk_depth_reg) ? item.nearest_depth - trk_depth_reg
                                                   : trk_depth_reg - item.nearest_depth;
        big        = (item.footprint_area > trk_area_reg) ? item.footprint_area : trk_area_reg;
        small_area = (item.footprint_area > trk_area_reg) ? trk_area_reg : item.footprint_area;
        pre        = item.flag && trk_vehicle_reg && (item.footprint_area != '0)
                     && (trk_area_reg != '0);
    end

    always_comb
    begin
        inter     = s1_az_reg * s1_h_reg;
        am_p      = $signed({1'b0, s1_ha_reg}) * s1_hm_reg;
        at_p      = $signed({1'b0, s1_hb_reg}) * s1_ht_reg;
        ratio_rhs = area_ratio_limit * s1_small_reg;
        ratio_hit = s1_pre_reg && (36'({s1_big_reg, 8'b0}) > ratio_rhs);
    end

    always_comb
    begin
        if (accept && (item.kind == KIND_SCORE))
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_free)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_valid_reg && s2_free)
        begin
            s2_valid_next = 1'b1;
        end
        else if (push)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_comb
    begin
        entry.inter     = s2_inter_reg;
        entry.uni       = 36'(s2_am_reg) + 36'(s2_at_reg) - 36'(s2_inter_reg);
        entry.depth_gap = s2_dd_reg;
        entry.vehicle   = s2_veh_reg;
        entry.ratio_hit = s2_hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            trk_center_reg     <= '0;
            trk_half_width_reg <= '0;
            trk_z_low_reg      <= '0;
            trk_z_high_reg     <= '0;
            trk_depth_reg      <= '0;
            trk_area_reg       <= '0;
            trk_vehicle_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (accept && (item.kind == KIND_LOAD))
            begin
                trk_center_reg     <= item.center;
                trk_half_width_reg <= item.half_width;
                trk_z_low_reg      <= item.z_low;
                trk_z_high_reg     <= item.z_high;
                trk_depth_reg      <= item.nearest_depth;
                trk_area_reg       <= item.footprint_area;
                trk_vehicle_reg    <= item.flag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.kind == KIND_SCORE))
        begin
            s1_az_reg    <= az_overlap;
            s1_h_reg     <= h_inter;
            s1_ha_reg    <= item.half_width;
            s1_hb_reg    <= trk_half_width_reg;
            s1_hm_reg    <= hm;
            s1_ht_reg    <= ht;
            s1_dd_reg    <= dd;
            s1_big_reg   <= big;
            s1_small_reg <= small_area;
            s1_pre_reg   <= pre;
            s1_veh_reg   <= trk_vehicle_reg;
        end
        if (s1_valid_reg && s2_free)
        begin
            s2_inter_reg <= inter;
            s2_am_reg    <= {am_p, 1'b0};
            s2_at_reg    <= {at_p, 1'b0};
            s2_dd_reg    <= s1_dd_reg;
            s2_veh_reg   <= s1_veh_reg;
            s2_hit_reg   <= ratio_hit;
        end
    end

endmodule

>>> rtl/core/pims_back.sv
`timescale 1ns / 1ps

module pims_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pims_pkg::cfg_t     cfg,
    input  logic               q_valid,
    input  pims_pkg::pair_t    q_head,
    output logic               q_pop,
    output pims_pkg::div_req_t div_req,
    input  pims_pkg::div_rsp_t div_rsp,
    pims_result_if.source      result
);
    import pims_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic [17:0] dd_reg;
    logic [17:0] dd_next;
    logic        veh_reg;
    logic        veh_next;
    logic        hit_reg;
    logic        hit_next;
    logic [16:0] iou_reg;
    logic [16:0] iou_next;
    logic [16:0] sc_reg;
    logic [16:0] sc_next;
    logic [16:0] prox_reg;
    logic [16:0] prox_next;
    logic        passed_reg;
    logic        passed_next;
    logic        shape_reg;
    logic        shape_next;
    logic [32:0] prod_a_reg;
    logic [32:0] prod_a_next;
    logic [32:0] prod_b_reg;
    logic [32:0] prod_b_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [16:0] out_score_reg;
    logic [16:0] out_score_next;
    logic        out_passed_reg;
    logic        out_passed_next;
    logic        out_shape_reg;
    logic        out_shape_next;

    logic [15:0] weight;
    logic [16:0] inv_weight;
    logic [33:0] sum;
    logic        out_free;
    logic        uni_pos;

    assign weight     = veh_reg ? cfg.vehicle_weight : cfg.other_weight;
    assign inv_weight = 17'(ONE_Q16) - {1'b0, weight};
    assign sum        = 34'(prod_a_reg) + 34'(prod_b_reg) + 34'(ONE_Q16 / 2);
    assign out_free   = !out_valid_reg || result.ready;
    assign uni_pos    = !q_head.uni[35] && (q_head.uni != '0);

    always_comb
    begin
        state_next      = state_reg;
        dd_next         = dd_reg;
        veh_next        = veh_reg;
        hit_next        = hit_reg;
        iou_next        = iou_reg;
        sc_next         = sc_reg;
        prox_next       = prox_reg;
        passed_next     = passed_reg;
        shape_next      = shape_reg;
        prod_a_next     = prod_a_reg;
        prod_b_next     = prod_b_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_score_next  = out_score_reg;
        out_passed_next = out_passed_reg;
        out_shape_next  = out_shape_reg;
        q_pop           = 1'b0;
        div_req         = '0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    dd_next  = q_head.depth_gap;
                    veh_next = q_head.vehicle;
                    hit_next = q_head.ratio_hit;
                    if (uni_pos)
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = DIV_W'(q_head.inter);
                        div_req.den   = q_head.uni[DIV_W-1:0];
                        state_next    = B_IOU;
                    end
                    else
                    begin
                        iou_next   = '0;
                        state_next = B_GATE;
                    end
                end
            end
            B_IOU:
            begin
                if (div_rsp.done)
                begin
                    iou_next   = div_rsp.quo;
                    state_next = B_GATE;
                end
            end
            B_GATE:
            begin
                if (iou_reg >= {1'b0, cfg.min_iou})
                begin
                    passed_next   = 1'b1;
                    shape_next    = (iou_reg < {1'b0, cfg.shape_check_iou}) && hit_reg;
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'(iou_reg - {1'b0, cfg.min_iou});
                    div_req.den   = DIV_W'(17'(ONE_Q16) - {1'b0, cfg.min_iou});
                    state_next    = B_SCORE;
                end
                else
                begin
                    passed_next = 1'b0;
                    shape_next  = 1'b0;
                    sc_next     = '0;
                    prox_next   = '0;
                    state_next  = B_MUL;
                end
            end
            B_SCORE:
            begin
                if (div_rsp.done)
                begin
                    sc_next = div_rsp.quo;
                    if (dd_reg < {2'b00, cfg.depth_scale})
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = DIV_W'({2'b00, cfg.depth_scale} - dd_reg);
                        div_req.den   = DIV_W'(cfg.depth_scale);
                        state_next    = B_PROX;
                    end
                    else
                    begin
                        prox_next  = '0;
                        state_next = B_MUL;
                    end
                end
            end
            B_PROX:
            begin
                if (div_rsp.done)
                begin
                    prox_next  = div_rsp.quo;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                prod_a_next = sc_reg * inv_weight;
                prod_b_next = prox_reg * weight;
                state_next  = B_OUT;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_score_next  = sum[32:16];
                    out_passed_next = passed_reg;
                    out_shape_next  = shape_reg;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dd_reg         <= dd_next;
        veh_reg        <= veh_next;
        hit_reg        <= hit_next;
        iou_reg        <= iou_next;
        sc_reg         <= sc_next;
        prox_reg       <= prox_next;
        passed_reg     <= passed_next;
        shape_reg      <= shape_next;
        prod_a_reg     <= prod_a_next;
        prod_b_reg     <= prod_b_next;
        out_score_reg  <= out_score_next;
        out_passed_reg <= out_passed_next;
        out_shape_reg  <= out_shape_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.score        = out_score_reg;
    assign result.passed_gate  = out_passed_reg;
    assign result.shape_change = out_shape_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import pims_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 45;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] center;
        logic [15:0]        half_width;
        logic signed [15:0] z_low;
        logic signed [15:0] z_high;
        logic [17:0]        nearest_depth;
        logic [19:0]        footprint_area;
        logic               flag;
    } item_word_t;

    typedef struct packed {
        logic [16:0] score;
        logic        passed_gate;
        logic        shape_change;
    } match_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    pims_item_if   item_ch ();
    pims_result_if result_ch ();

    perspective_iou_match_score_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    cfg_t        model_cfg;
    item_word_t  tracker;
    match_word_t expected_matches[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          item_gaps_on = 1'b1;
    bit          result_stalls_on = 1'b1;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic match_word_t predict_match(item_word_t m, item_word_t t, cfg_t c);
        longint      ha, hb, d, az_overlap, h_inter, inter, area_m, area_t, uni, iou;
        longint      gate, rescaled, big_area, low_area, diff, prox, w, total;
        logic [15:0] d_wrap;
        match_word_t r;
        r = '0;
        ha = longint'(m.half_width);
        hb = longint'(t.half_width);
        d_wrap = m.center - t.center;
        d = longint'($signed(d_wrap));
        if (d < 0)
            d = -d;
        az_overlap = lmax(0, lmin(ha, d + hb) - lmax(-ha, d - hb));
        h_inter = lmax(0, lmin(longint'(m.z_high), longint'(t.z_high))
                          - lmax(longint'(m.z_low), longint'(t.z_low)));
        inter = az_overlap * h_inter;
        area_m = 2 * ha * (longint'(m.z_high) - longint'(m.z_low));
        area_t = 2 * hb * (longint'(t.z_high) - longint'(t.z_low));
        uni = area_m + area_t - inter;
        iou = 0;
        if (uni > 0)
        begin
            iou = (inter * ONE_Q16) / uni;
            if (iou > ONE_Q16)
                iou = ONE_Q16;
        end
        gate = longint'(c.min_iou);
        if (iou >= gate)
        begin
            r.passed_gate = 1'b1;
            rescaled = ((iou - gate) * ONE_Q16) / (ONE_Q16 - gate);
            if (iou < longint'(c.shape_check_iou) && t.flag && m.flag
                && m.footprint_area != 0 && t.footprint_area != 0)
            begin
                big_area = lmax(longint'(m.footprint_area), longint'(t.footprint_area));
                low_area = lmin(longint'(m.footprint_area), longint'(t.footprint_area));
                if (big_area * 256 > longint'(c.area_ratio_limit) * low_area)
                    r.shape_change = 1'b1;
            end
            diff = longint'(m.nearest_depth) - longint'(t.nearest_depth);
            if (diff < 0)
                diff = -diff;
            prox = 0;
            if (diff < longint'(c.depth_scale))
                prox = ((longint'(c.depth_scale) - diff) * ONE_Q16) / longint'(c.depth_scale);
            w = t.flag ? longint'(c.vehicle_weight) : longint'(c.other_weight);
            total = rescaled * (ONE_Q16 - w) + prox * w + 32768;
            r.score = 17'(total >> 16);
        end
        return r;
    endfunction

    function automatic item_word_t make_item(logic kind, int center, int half_width, int z_low,
                                             int z_high, int depth, int area, logic flag);
        item_word_t w;
        w.kind = kind;
        w.center = 16'(center);
        w.half_width = 16'(half_width);
        w.z_low = 16'(z_low);
        w.z_high = 16'(z_high);
        w.nearest_depth = 18'(depth);
        w.footprint_area = 20'(area);
        w.flag = flag;
        return w;
    endfunction

    function automatic logic [15:0] pick16(int lo, int hi, int typ_hi);
        int r;
        r = $urandom_range(0, 4);
        if (r == 0)
            return 16'(lo);
        if (r == 1)
            return 16'(hi);
        return 16'($urandom_range(lo, typ_hi));
    endfunction

    task automatic send_word(input item_word_t w);
        int gap;
        gap = item_gaps_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.kind           <= w.kind;
        item_ch.center         <= w.center;
        item_ch.half_width     <= w.half_width;
        item_ch.z_low          <= w.z_low;
        item_ch.z_high         <= w.z_high;
        item_ch.nearest_depth  <= w.nearest_depth;
        item_ch.footprint_area <= w.footprint_area;
        item_ch.flag           <= w.flag;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (w.kind == KIND_LOAD)
            tracker = w;
        else
            expected_matches.push_back(predict_match(w, tracker, model_cfg));
    endtask

    task automatic drain_and_settle;
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [15:0] value);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        case (index)
            REG_MIN_IOU:          model_cfg.min_iou = value;
            REG_SHAPE_CHECK_IOU:  model_cfg.shape_check_iou = value;
            REG_AREA_RATIO_LIMIT: model_cfg.area_ratio_limit = value;
            REG_DEPTH_SCALE:      model_cfg.depth_scale = value;
            REG_VEHICLE_WEIGHT:   model_cfg.vehicle_weight = value;
            REG_OTHER_WEIGHT:     model_cfg.other_weight = value;
            default:              ;
        endcase
    endtask

    task automatic program_registers(input cfg_t c);
        write_reg(REG_MIN_IOU, c.min_iou);
        write_reg(REG_SHAPE_CHECK_IOU, c.shape_check_iou);
        write_reg(REG_AREA_RATIO_LIMIT, c.area_ratio_limit);
        write_reg(REG_DEPTH_SCALE, c.depth_scale);
        write_reg(REG_VEHICLE_WEIGHT, c.vehicle_weight);
        write_reg(REG_OTHER_WEIGHT, c.other_weight);
    endtask

    task automatic probe_registers;
        send_word(make_item(KIND_LOAD, 0, 1000, 0, 1000, 10000, 1000, 1'b1));
        send_word(make_item(KIND_SCORE, 1200, 1000, 0, 1000, 10001, 5000, 1'b1));
        send_word(make_item(KIND_LOAD, 0, 1000, 0, 1000, 10000, 1000, 1'b0));
        send_word(make_item(KIND_SCORE, 0, 1000, 0, 1000, 9999, 1000, 1'b1));
    endtask

    task automatic test_reset_defaults;
        send_word(make_item(KIND_SCORE, 0, 0, 0, 0, 0, 0, 1'b0));
        send_word(make_item(KIND_SCORE, 100, 500, -200, 800, 1000, 4096, 1'b1));
    endtask

    task automatic test_directed_geometry;
        send_word(make_item(KIND_LOAD, 0, 1000, 0, 1000, 10000, 1000, 1'b1));
        send_word(make_item(KIND_SCORE, 0, 1000, 0, 1000, 10000, 1000, 1'b1));
        send_word(make_item(KIND_SCORE, 1200, 1000, 0, 1000, 10500, 5000, 1'b1));
        send_word(make_item(KIND_SCORE, 1200, 1000, 0, 1000, 13000, 5000, 1'b0));
        send_word(make_item(KIND_SCORE, 0, 1000, 1000, 0, 10000, 1000, 1'b1));
        send_word(make_item(KIND_SCORE, 0, 1000, 900, 0, 10000, 1000, 1'b1));
        send_word(make_item(KIND_LOAD, 32767, 32768, -32768, 32767, 262143, 1048575, 1'b0));
        send_word(make_item(KIND_SCORE, -32768, 32768, -32768, 32767, 0, 0, 1'b1));
        send_word(make_item(KIND_SCORE, 0, 65535, -32768, 32767, 262143, 1048575, 1'b0));
        send_word(make_item(KIND_SCORE, 100, 0, -5, 5, 262000, 1, 1'b1));
        send_word(make_item(KIND_LOAD, -32768, 40000, -100, 100, 0, 0, 1'b1));
        send_word(make_item(KIND_SCORE, 32767, 40000, -100, 100, 1500, 500, 1'b1));
    endtask

    task automatic test_register_extremes;
        drain_and_settle();
        program_registers('{16'd0, 16'd65535, 16'd256, 16'd1, 16'd65535, 16'd0});
        probe_registers();
        drain_and_settle();
        program_registers('{16'd65535, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd65535});
        probe_registers();
        drain_and_settle();
        program_registers('{16'd6554, 16'd65535, 16'd256, 16'd0, 16'd32768, 16'd32768});
        probe_registers();
    endtask

    task automatic test_random_traffic;
        cfg_t       c;
        item_word_t w;
        int         pick, span, height, dz, zl;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_and_settle();
            c.min_iou          = pick16(0, 65535, 20000);
            c.shape_check_iou  = pick16(0, 65535, 65535);
            c.area_ratio_limit = pick16(256, 65535, 1024);
            c.depth_scale      = pick16(1, 65535, 8000);
            c.vehicle_weight   = pick16(0, 65535, 65535);
            c.other_weight     = pick16(0, 65535, 65535);
            program_registers(c);
            item_gaps_on     = (phase % 4) < 2;
            result_stalls_on = (phase % 2) == 0;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 12)
                begin
                    zl = int'($urandom_range(0, 6000)) - 3000;
                    w = make_item(KIND_LOAD, $urandom_range(0, 65535), $urandom_range(1, 6000),
                                  zl, zl + int'($urandom_range(1, 5000)),
                                  $urandom_range(0, 262143), $urandom_range(1, 1048575),
                                  1'($urandom_range(0, 1)));
                end
                else if (pick < 22)
                begin
                    w = make_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
                end
                else
                begin
                    span = int'(tracker.half_width);
                    if (span < 4)
                        span = 4;
                    height = int'(tracker.z_high) - int'(tracker.z_low);
                    if (height < 4)
                        height = 4;
                    dz = height / 4;
                    w = make_item(KIND_SCORE,
                                  int'(tracker.center) + int'($urandom_range(0, 2 * span + 2))
                                      - (span + 1),
                                  span + int'($urandom_range(0, span / 2 + 1)) - span / 4,
                                  int'(tracker.z_low) + int'($urandom_range(0, 2 * dz)) - dz,
                                  int'(tracker.z_high) + int'($urandom_range(0, 2 * dz)) - dz,
                                  int'(tracker.nearest_depth) + int'($urandom_range(0, 6000))
                                      - 3000,
                                  (int'(tracker.footprint_area)
                                      * int'($urandom_range(64, 1024))) >> 8,
                                  1'($urandom_range(0, 1)));
                end
                send_word(w);
            end
        end
    endtask

    initial
    begin : result_checker
        int          stall;
        match_word_t want;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = result_stalls_on ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            if (expected_matches.size() == 0)
            begin
                $error("unexpected result word: score %0d", result_ch.score);
                fail_count++;
            end
            else
            begin
                want = expected_matches.pop_front();
                if (result_ch.score !== want.score)
                begin
                    $error("score: expected %0d, actual %0d", want.score, result_ch.score);
                    fail_count++;
                end
                if (result_ch.passed_gate !== want.passed_gate)
                begin
                    $error("passed_gate: expected %0d, actual %0d",
                           want.passed_gate, result_ch.passed_gate);
                    fail_count++;
                end
                if (result_ch.shape_change !== want.shape_change)
                begin
                    $error("shape_change: expected %0d, actual %0d",
                           want.shape_change, result_ch.shape_change);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : test_sequence
        item_ch.valid          <= 1'b0;
        item_ch.kind           <= KIND_LOAD;
        item_ch.center         <= '0;
        item_ch.half_width     <= '0;
        item_ch.z_low          <= '0;
        item_ch.z_high         <= '0;
        item_ch.nearest_depth  <= '0;
        item_ch.footprint_area <= '0;
        item_ch.flag           <= 1'b0;
        wr_en                  <= 1'b0;
        wr_index               <= REG_MIN_IOU;
        wr_data                <= '0;
        model_cfg = CFG_RESET;
        tracker = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_geometry();
        test_register_extremes();
        test_random_traffic();
        drain_and_settle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
